// ===== hdl/ttcp_pkg.sv =====
package ttcp_pkg;

    // Number formats
    localparam int COORD_FRAC_BITS = 16;
    localparam int ROT_FRAC        = 14;
    localparam int EDGE_W          = 14;
    localparam int NUM_W           = 55;
    localparam int DIV_STEPS       = NUM_W;
    localparam int NDC_ONE         = 65536;
    localparam int SCR_SHIFT       = 17;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    // Pipeline depths of the lanes
    localparam int VTX_LAT   = 4;
    localparam int CULL_LAT  = 9;
    localparam int PROJ_LAT  = DIV_STEPS + 5;
    localparam int TOTAL_LAT = VTX_LAT + PROJ_LAT;
    localparam int KEEP_DLY  = PROJ_LAT - CULL_LAT;

    localparam logic signed [49:0] TRANSLATE = 50'sd8 <<< COORD_FRAC_BITS;
    localparam logic [NUM_W-1:0]   NDC_LIMIT = NUM_W'(1) << 40;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [15:0] trig_t;
    typedef logic [23:0]        scale_t;
    typedef logic [12:0]        size_t;
    typedef logic signed [15:0] scr_t;
    typedef logic [3:0]         shade_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
        coord_t cx;
        coord_t cy;
        coord_t cz;
    } tri_word_t;

    typedef struct packed {
        scr_t   sx0;
        scr_t   sy0;
        scr_t   sx1;
        scr_t   sy1;
        scr_t   sx2;
        scr_t   sy2;
        shade_t shade;
    } res_word_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    // Rotation settings handed to every vertex lane
    typedef struct packed {
        trig_t zc;
        trig_t zs;
        trig_t xc;
        trig_t xs;
    } rot_cfg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_Z_COS     = 3'd0,
        REG_ROT_Z_SIN     = 3'd1,
        REG_ROT_X_COS     = 3'd2,
        REG_ROT_X_SIN     = 3'd3,
        REG_PROJ_X_SCALE  = 3'd4,
        REG_PROJ_Y_SCALE  = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } cfg_index_t;

    // Clamp a wide signed value to the 32 bit signed range.
    function automatic coord_t sat32(input logic signed [49:0] v);
        coord_t r;
        if (v > 50'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -50'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/ttcp_vertex_lane.sv =====
module ttcp_vertex_lane (
    input  logic              clk,
    input  logic              en,
    input  ttcp_pkg::coord_t  x,
    input  ttcp_pkg::coord_t  y,
    input  ttcp_pkg::coord_t  z,
    input  ttcp_pkg::rot_cfg_t rot,
    output ttcp_pkg::vec3_t   p
);
    import ttcp_pkg::*;

    logic signed [47:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [47:0] m4_reg, m5_reg, m6_reg, m7_reg;
    coord_t             z1_reg, z2_reg;
    coord_t             x1_reg, y1_reg, x3_reg;
    vec3_t              p_reg;
    logic signed [48:0] sum_x, sum_y, sum_py, sum_pz;
    coord_t             x1_next, y1_next, py_next, pz_pre, pz_next;

    // Rotation about Z, then about X, then the push along Z.
    always_comb
    begin
        sum_x   = m0_reg + m1_reg;
        sum_y   = m3_reg - m2_reg;
        x1_next = sat32(50'(sum_x >>> ROT_FRAC));
        y1_next = sat32(50'(sum_y >>> ROT_FRAC));
        sum_py  = m4_reg + m5_reg;
        sum_pz  = m7_reg - m6_reg;
        py_next = sat32(50'(sum_py >>> ROT_FRAC));
        pz_pre  = sat32(50'(sum_pz >>> ROT_FRAC));
        pz_next = sat32(50'(pz_pre) + TRANSLATE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg <= x * rot.zc;
            m1_reg <= y * rot.zs;
            m2_reg <= x * rot.zs;
            m3_reg <= y * rot.zc;
            z1_reg <= z;
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z2_reg <= z1_reg;
            m4_reg <= y1_reg * rot.xc;
            m5_reg <= z2_reg * rot.xs;
            m6_reg <= y1_reg * rot.xs;
            m7_reg <= z2_reg * rot.xc;
            x3_reg <= x1_reg;
            p_reg.x <= x3_reg;
            p_reg.y <= py_next;
            p_reg.z <= pz_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/ttcp_cull.sv =====
module ttcp_cull (
    input  logic             clk,
    input  logic             en,
    input  ttcp_pkg::vec3_t  v0,
    input  ttcp_pkg::vec3_t  v1,
    input  ttcp_pkg::vec3_t  v2,
    output logic             keep,
    output ttcp_pkg::shade_t shade
);
    import ttcp_pkg::*;

    vec3_t                    p0_reg [5];
    logic signed [32:0]       e_reg [6];
    logic signed [32:0]       e2_reg [6];
    logic [4:0]               sh_reg;
    logic signed [EDGE_W-1:0] er_reg [6];
    logic signed [27:0]       cp_reg [6];
    logic signed [28:0]       n_reg [3];
    logic signed [60:0]       dp_reg [3];
    logic [55:0]              sq_reg [3];
    logic                     neg_reg;
    logic                     keep7_reg, lit7_reg;
    logic [57:0]              len2_reg;
    logic [63:0]              top_reg;
    logic                     keep8_reg, lit8_reg;
    logic [11:0]              cmp_reg;
    logic                     keep_reg;
    shade_t                   shade_reg;

    logic [31:0]              msk;
    logic [4:0]               sh_next;
    logic signed [32:0]       e_sh [6];
    logic [27:0]              nmag [3];
    logic signed [62:0]       dot;
    logic [11:0]              cmp_next;
    shade_t                   shade_next;

    // Common shift search: the highest sign change over every component of both edges.
    always_comb
    begin
        msk = '0;
        for (int j = 0; j < 6; j++)
            msk = msk | (e_reg[j][31:0] ^ e_reg[j][32:1]);
        sh_next = '0;
        for (int i = 12; i < 32; i++)
            if (msk[i])
                sh_next = 5'(i - 12);
    end

    // Reduced edges, normal magnitudes and the dot product.
    always_comb
    begin
        for (int j = 0; j < 6; j++)
            e_sh[j] = e2_reg[j] >>> sh_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (n_reg[i] < 0)
                nmag[i] = 28'(-n_reg[i]);
            else
                nmag[i] = 28'(n_reg[i]);
        end
        dot = 63'(dp_reg[0]) + 63'(dp_reg[1]) + 63'(dp_reg[2]);
    end

    // One compare lane for each candidate shade level.
    always_comb
    begin
        for (int k = 1; k <= 12; k++)
            cmp_next[k-1] = (64'(len2_reg) * 64'(k * k)) <= top_reg;
        shade_next = '0;
        for (int k = 1; k <= 12; k++)
            if (cmp_reg[k-1])
                shade_next = 4'(k);
        if (!lit8_reg)
            shade_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= 33'(v1.x) - 33'(v0.x);
            e_reg[1] <= 33'(v1.y) - 33'(v0.y);
            e_reg[2] <= 33'(v1.z) - 33'(v0.z);
            e_reg[3] <= 33'(v2.x) - 33'(v0.x);
            e_reg[4] <= 33'(v2.y) - 33'(v0.y);
            e_reg[5] <= 33'(v2.z) - 33'(v0.z);
            p0_reg[0] <= v0;
            for (int i = 1; i < 5; i++)
                p0_reg[i] <= p0_reg[i-1];
            sh_reg <= sh_next;
            for (int j = 0; j < 6; j++)
            begin
                e2_reg[j] <= e_reg[j];
                er_reg[j] <= e_sh[j][EDGE_W-1:0];
            end
            cp_reg[0] <= er_reg[1] * er_reg[5];
            cp_reg[1] <= er_reg[2] * er_reg[4];
            cp_reg[2] <= er_reg[2] * er_reg[3];
            cp_reg[3] <= er_reg[0] * er_reg[5];
            cp_reg[4] <= er_reg[0] * er_reg[4];
            cp_reg[5] <= er_reg[1] * er_reg[3];
            n_reg[0] <= 29'(cp_reg[0]) - 29'(cp_reg[1]);
            n_reg[1] <= 29'(cp_reg[2]) - 29'(cp_reg[3]);
            n_reg[2] <= 29'(cp_reg[4]) - 29'(cp_reg[5]);
            dp_reg[0] <= n_reg[0] * p0_reg[4].x;
            dp_reg[1] <= n_reg[1] * p0_reg[4].y;
            dp_reg[2] <= n_reg[2] * p0_reg[4].z;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= nmag[i] * nmag[i];
            neg_reg <= n_reg[2] < 0;
            keep7_reg <= dot < 0;
            lit7_reg  <= neg_reg && ((sq_reg[0] | sq_reg[1]) != '0);
            len2_reg  <= 58'(sq_reg[0]) + 58'(sq_reg[1]) + 58'(sq_reg[2]);
            top_reg   <= 64'(sq_reg[2]) * 64'd169;
            keep8_reg <= keep7_reg;
            lit8_reg  <= lit7_reg;
            cmp_reg   <= cmp_next;
            keep_reg  <= keep8_reg;
            shade_reg <= shade_next;
        end
    end

    assign keep  = keep_reg;
    assign shade = shade_reg;

endmodule

// ===== hdl/ttcp_proj_lane.sv =====
module ttcp_proj_lane (
    input  logic             clk,
    input  logic             en,
    input  ttcp_pkg::coord_t coord,
    input  ttcp_pkg::coord_t z,
    input  ttcp_pkg::scale_t scale,
    input  ttcp_pkg::size_t  size,
    output ttcp_pkg::scr_t   scr
);
    import ttcp_pkg::*;

    logic signed [55:0]      prod_reg;
    coord_t                  z1_reg;
    logic [31:0]             rem_reg [DIV_STEPS+1];
    logic [NUM_W-1:0]        num_reg [DIV_STEPS+1];
    logic [31:0]             dz_reg [DIV_STEPS+1];
    logic signed [39:0]      alt_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0]      neg_reg;
    logic [DIV_STEPS:0]      zero_reg;
    logic signed [41:0]      ndc_reg;
    logic signed [55:0]      v_reg;
    scr_t                    scr_reg;

    logic [55:0]             pmag;
    logic [32:0]             zmag;
    logic [32:0]             t_div [DIV_STEPS];
    logic [32:0]             d_div [DIV_STEPS];
    logic [DIV_STEPS-1:0]    ge_div;
    logic [NUM_W-1:0]        q;
    logic signed [41:0]      qs;
    logic signed [41:0]      ndc_next;
    logic [55:0]             vmag;
    logic [38:0]             rmag;
    scr_t                    scr_next;

    // Operand magnitudes for the divider.
    always_comb
    begin
        if (prod_reg < 0)
            pmag = 56'(-prod_reg);
        else
            pmag = 56'(prod_reg);
        if (z1_reg < 0)
            zmag = -33'(z1_reg);
        else
            zmag = 33'(z1_reg);
    end

    // One restoring division step per stage.
    always_comb
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            t_div[s]  = {rem_reg[s], num_reg[s][NUM_W-1]};
            d_div[s]  = t_div[s] - {1'b0, dz_reg[s]};
            ge_div[s] = t_div[s] >= {1'b0, dz_reg[s]};
        end
    end

    // Sign, clamp and the camera-plane case, then mapping to the screen.
    always_comb
    begin
        q = num_reg[DIV_STEPS];
        if (q > NDC_LIMIT)
            qs = {1'b0, NDC_LIMIT[40:0]};
        else
            qs = {1'b0, q[40:0]};
        if (zero_reg[DIV_STEPS])
            ndc_next = 42'(alt_reg[DIV_STEPS]);
        else if (neg_reg[DIV_STEPS])
            ndc_next = -qs;
        else
            ndc_next = qs;

        if (v_reg < 0)
            vmag = 56'(-v_reg);
        else
            vmag = 56'(v_reg);
        rmag = 39'(vmag >> SCR_SHIFT);
        if (v_reg < 0)
        begin
            if (rmag > 39'd32768)
                scr_next = 16'sh8000;
            else
                scr_next = 16'(-rmag);
        end
        else
        begin
            if (rmag > 39'd32767)
                scr_next = 16'sh7fff;
            else
                scr_next = rmag[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= coord * $signed({1'b0, scale});
            z1_reg      <= z;
            rem_reg[0]  <= '0;
            num_reg[0]  <= pmag[NUM_W-1:0];
            dz_reg[0]   <= zmag[31:0];
            alt_reg[0]  <= 40'(prod_reg >>> COORD_FRAC_BITS);
            neg_reg[0]  <= prod_reg[55] ^ z1_reg[31];
            zero_reg[0] <= z1_reg == '0;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                rem_reg[s+1]  <= ge_div[s] ? d_div[s][31:0] : t_div[s][31:0];
                num_reg[s+1]  <= {num_reg[s][NUM_W-2:0], ge_div[s]};
                dz_reg[s+1]   <= dz_reg[s];
                alt_reg[s+1]  <= alt_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
            ndc_reg <= ndc_next;
            v_reg   <= (ndc_reg + 42'(NDC_ONE)) * $signed({1'b0, size});
            scr_reg <= scr_next;
        end
    end

    assign scr = scr_reg;

endmodule

// ===== hdl/triangle_transform_cull_project_unit.sv =====
// Triangle transform, back-face cull and perspective projection.
// Input channel tri_*: one word is one triangle of three vertices, taken at a
// clock edge where tri_valid is high and tri_stall is low.
// Output channel res_*: one word for each triangle that faces the camera,
// carrying six screen coordinates and a shade level; culled triangles give
// no word. The receiver holds res_stall high to keep the word in place.
// The user must write settings through cfg_write, cfg_index and cfg_data only
// while the unit is idle; the block itself does not enforce this.
// Throughput: one triangle per clock cycle while tri_stall is low. The delay
// from accept to res_valid is set mostly by the 55-step division pipeline
// in each of the six projection lanes.
// A stalled result sits in the output register and a second word fits in
// a skid register; only when both are full does tri_stall rise and the
// whole pipeline hold.
// Reset clears the pipeline and output valid flags and loads the default
// settings; no clearing pass is needed.
module triangle_transform_cull_project_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 tri_valid,
    output logic                                 tri_stall,
    input  ttcp_pkg::tri_word_t                  tri_word,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output ttcp_pkg::res_word_t                  res_word,
    input  logic                                 cfg_write,
    input  logic [ttcp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttcp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ttcp_pkg::*;

    trig_t                rot_z_cos_reg, rot_z_sin_reg, rot_x_cos_reg, rot_x_sin_reg;
    scale_t               proj_x_scale_reg, proj_y_scale_reg;
    size_t                screen_width_reg, screen_height_reg;
    rot_cfg_t             rot;

    logic                 en;
    logic [TOTAL_LAT-1:0] vld_reg;
    vec3_t                p0, p1, p2;
    logic                 cull_keep;
    shade_t               cull_shade;
    logic                 keep_dly_reg [KEEP_DLY];
    shade_t               shade_dly_reg [KEEP_DLY];
    scr_t                 sx0, sy0, sx1, sy1, sx2, sy2;
    res_word_t            pipe_word;
    logic                 arrive;

    logic                 res_valid_reg, res_valid_next;
    logic                 skid_full_reg, skid_full_next;
    res_word_t            res_word_reg, res_word_next;
    res_word_t            skid_word_reg, skid_word_next;

    // Settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_z_cos_reg     <= 16'sd16384;
            rot_z_sin_reg     <= '0;
            rot_x_cos_reg     <= 16'sd16384;
            rot_x_sin_reg     <= '0;
            proj_x_scale_reg  <= 24'd65536;
            proj_y_scale_reg  <= 24'd65536;
            screen_width_reg  <= 13'd256;
            screen_height_reg <= 13'd240;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROT_Z_COS:     rot_z_cos_reg     <= cfg_data[15:0];
                REG_ROT_Z_SIN:     rot_z_sin_reg     <= cfg_data[15:0];
                REG_ROT_X_COS:     rot_x_cos_reg     <= cfg_data[15:0];
                REG_ROT_X_SIN:     rot_x_sin_reg     <= cfg_data[15:0];
                REG_PROJ_X_SCALE:  proj_x_scale_reg  <= cfg_data[23:0];
                REG_PROJ_Y_SCALE:  proj_y_scale_reg  <= cfg_data[23:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign rot = '{zc: rot_z_cos_reg, zs: rot_z_sin_reg,
                   xc: rot_x_cos_reg, xs: rot_x_sin_reg};

    // The whole pipeline moves unless the skid register is occupied.
    assign en        = !skid_full_reg;
    assign tri_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], tri_valid};
    end

    // Vertex lanes
    ttcp_vertex_lane u_vtx0 (.clk(clk), .en(en), .x(tri_word.ax), .y(tri_word.ay),
                             .z(tri_word.az), .rot(rot), .p(p0));
    ttcp_vertex_lane u_vtx1 (.clk(clk), .en(en), .x(tri_word.bx), .y(tri_word.by),
                             .z(tri_word.bz), .rot(rot), .p(p1));
    ttcp_vertex_lane u_vtx2 (.clk(clk), .en(en), .x(tri_word.cx), .y(tri_word.cy),
                             .z(tri_word.cz), .rot(rot), .p(p2));

    // Face test and shading
    ttcp_cull u_cull (.clk(clk), .en(en), .v0(p0), .v1(p1), .v2(p2),
                      .keep(cull_keep), .shade(cull_shade));

    // Projection lanes, one for each screen coordinate
    ttcp_proj_lane u_px0 (.clk(clk), .en(en), .coord(p0.x), .z(p0.z),
                          .scale(proj_x_scale_reg), .size(screen_width_reg), .scr(sx0));
    ttcp_proj_lane u_py0 (.clk(clk), .en(en), .coord(p0.y), .z(p0.z),
                          .scale(proj_y_scale_reg), .size(screen_height_reg), .scr(sy0));
    ttcp_proj_lane u_px1 (.clk(clk), .en(en), .coord(p1.x), .z(p1.z),
                          .scale(proj_x_scale_reg), .size(screen_width_reg), .scr(sx1));
    ttcp_proj_lane u_py1 (.clk(clk), .en(en), .coord(p1.y), .z(p1.z),
                          .scale(proj_y_scale_reg), .size(screen_height_reg), .scr(sy1));
    ttcp_proj_lane u_px2 (.clk(clk), .en(en), .coord(p2.x), .z(p2.z),
                          .scale(proj_x_scale_reg), .size(screen_width_reg), .scr(sx2));
    ttcp_proj_lane u_py2 (.clk(clk), .en(en), .coord(p2.y), .z(p2.z),
                          .scale(proj_y_scale_reg), .size(screen_height_reg), .scr(sy2));

    // The face decision waits here until the projection lanes catch up.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            keep_dly_reg[0]  <= cull_keep;
            shade_dly_reg[0] <= cull_shade;
            for (int i = 1; i < KEEP_DLY; i++)
            begin
                keep_dly_reg[i]  <= keep_dly_reg[i-1];
                shade_dly_reg[i] <= shade_dly_reg[i-1];
            end
        end
    end

    // Merge the lanes into one result word.
    assign pipe_word = '{sx0: sx0, sy0: sy0, sx1: sx1, sy1: sy1, sx2: sx2, sy2: sy2,
                         shade: shade_dly_reg[KEEP_DLY-1]};
    assign arrive    = en && vld_reg[TOTAL_LAT-1] && keep_dly_reg[KEEP_DLY-1];

    // Output register with a skid register behind it.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;
        skid_full_next = skid_full_reg;
        skid_word_next = skid_word_reg;
        if (!res_valid_reg || !res_stall)
        begin
            if (skid_full_reg)
            begin
                res_valid_next = 1'b1;
                res_word_next  = skid_word_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                res_valid_next = arrive;
                res_word_next  = pipe_word;
            end
        end
        else if (arrive)
        begin
            skid_full_next = 1'b1;
            skid_word_next = pipe_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg  <= res_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> res_valid_reg)
        else $error("skid register holds a word while the output register is empty");
    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(res_valid_reg && res_stall))
        else $error("skid register filled without a stalled output word");
    a_shade_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_word_reg.shade <= 4'd12))
        else $error("shade level beyond twelve");
`endif

endmodule
